[src/cmmn_pkg.sv]
// Shared types and constants for the column min-max normalizer.
`timescale 1ns / 1ps
`default_nettype none

package cmmn_pkg;

    localparam int OP_BITS        = 2;
    localparam int COLUMN_BITS    = 10;
    localparam int COLUMN_LIMIT   = 2 ** COLUMN_BITS;
    localparam int SCALED_BITS    = 17;
    localparam int FRAC_BITS      = 15;
    localparam int DIV_COUNT_BITS = $clog2(FRAC_BITS + 1);

    localparam logic [SCALED_BITS-1:0] ONE_Q15 = SCALED_BITS'(1) << FRAC_BITS;

    typedef enum logic [OP_BITS-1:0] {
        OP_SCAN      = 2'd0,
        OP_NORMALIZE = 2'd1,
        OP_CLEAR     = 2'd2
    } t_op;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear_start;
    } t_stats_ctl;

    typedef struct packed {
        logic busy;
    } t_stats_sts;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

`default_nettype wire

[src/cmmn_in_if.sv]
// Input channel interface: operation, column and element value.
`timescale 1ns / 1ps
`default_nettype none

interface cmmn_in_if #(
    parameter int VALUE_BITS = 16
);
    logic                                 valid;
    logic                                 ready;
    logic [cmmn_pkg::OP_BITS-1:0]         operation;
    logic [cmmn_pkg::COLUMN_BITS-1:0]     column;
    logic signed [VALUE_BITS-1:0]         value;

    modport source (output valid, operation, column, value, input ready);
    modport sink   (input valid, operation, column, value, output ready);
endinterface

`default_nettype wire

[src/cmmn_out_if.sv]
// Output channel interface: scaled result and pass-through flag.
`timescale 1ns / 1ps
`default_nettype none

interface cmmn_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [cmmn_pkg::SCALED_BITS-1:0] scaled;
    logic                                 passed_through;

    modport source (output valid, scaled, passed_through, input ready);
    modport sink   (input valid, scaled, passed_through, output ready);
endinterface

`default_nettype wire

[src/cmmn_stats.sv]
// Per-column statistics memory {seen, min, max} with a seen-clearing sweep.
`timescale 1ns / 1ps
`default_nettype none

module cmmn_stats #(
    parameter int DEPTH      = 1024,
    parameter int AW         = 10,
    parameter int VALUE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cmmn_pkg::t_stats_ctl         i_ctl,
    input  logic [AW-1:0]                i_addr,
    input  logic signed [VALUE_BITS-1:0] i_wr_min,
    input  logic signed [VALUE_BITS-1:0] i_wr_max,
    output logic                         o_rd_seen,
    output logic signed [VALUE_BITS-1:0] o_rd_min,
    output logic signed [VALUE_BITS-1:0] o_rd_max,
    output cmmn_pkg::t_stats_sts         o_sts
);
    localparam int WW = 2 * VALUE_BITS + 1;

    logic [WW-1:0] r_mem [DEPTH];
    logic [WW-1:0] r_rd;
    logic          r_sweep_active;
    logic [AW-1:0] r_sweep_addr;

    // sweep runs after reset and after each clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_active <= 1'b1;
            r_sweep_addr   <= '0;
        end else if (r_sweep_active) begin
            if (r_sweep_addr == AW'(DEPTH - 1)) begin
                r_sweep_active <= 1'b0;
            end
            r_sweep_addr <= r_sweep_addr + AW'(1);
        end else if (i_ctl.clear_start) begin
            r_sweep_active <= 1'b1;
            r_sweep_addr   <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sweep_active) begin
            r_mem[r_sweep_addr] <= '0;
        end else if (i_ctl.wr_en) begin
            r_mem[i_addr] <= {1'b1, i_wr_min, i_wr_max};
        end
        if (i_ctl.rd_en) begin
            r_rd <= r_mem[i_addr];
        end
    end

    assign o_rd_seen  = r_rd[WW-1];
    assign o_rd_min   = r_rd[WW-2:VALUE_BITS];
    assign o_rd_max   = r_rd[VALUE_BITS-1:0];
    assign o_sts.busy = r_sweep_active;

`ifndef ASSERT_OFF
    a_no_write_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sweep_active |-> !i_ctl.wr_en)
        else $error("stats write during clearing sweep");
`endif

endmodule

`default_nettype wire

[src/cmmn_divider.sv]
// Restoring divider, one quotient bit per cycle, fraction diff/range.
`timescale 1ns / 1ps
`default_nettype none

module cmmn_divider #(
    parameter int VALUE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cmmn_pkg::t_div_ctl                 i_ctl,
    input  logic [VALUE_BITS-1:0]              i_dividend,
    input  logic [VALUE_BITS-1:0]              i_divisor,
    output logic [cmmn_pkg::FRAC_BITS-1:0]     o_quotient,
    output cmmn_pkg::t_div_sts                 o_sts
);
    localparam int CB = cmmn_pkg::DIV_COUNT_BITS;
    localparam int QB = cmmn_pkg::FRAC_BITS;

    logic [VALUE_BITS-1:0] r_rem;
    logic [VALUE_BITS-1:0] r_div;
    logic [QB-1:0]         r_quot;
    logic [CB-1:0]         r_count;
    logic                  r_busy;
    logic                  r_done;
    logic [VALUE_BITS:0]   w_shift;
    logic [VALUE_BITS:0]   w_trial;

    // remainder stays below divisor, so doubling fits one extra bit
    assign w_shift = {r_rem, 1'b0};
    assign w_trial = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_count == CB'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem   <= i_dividend;
            r_div   <= i_divisor;
            r_count <= CB'(QB);
        end else if (r_busy) begin
            if (!w_trial[VALUE_BITS]) begin
                r_rem <= w_trial[VALUE_BITS-1:0];
            end else begin
                r_rem <= w_shift[VALUE_BITS-1:0];
            end
            r_quot  <= {r_quot[QB-2:0], ~w_trial[VALUE_BITS]};
            r_count <= r_count - CB'(1);
        end
    end

    assign o_quotient = r_quot;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");
`endif

endmodule

`default_nettype wire

[src/column_min_max_normalizer_unit.sv]
// Column min-max normalizer top: scan folds min/max, normalize scales to Q1.15.
// One beat at a time. Scan reads the stats at accept and writes them back in S_SCAN;
// normalize goes through S_NORM and S_CMP, then S_DIV with the 15-step bit-serial
// divider unless clamped or passed through; S_DONE waits for a free output register.
// Clear and reset start a sweep over all min(MAX_COLUMNS,1024) stats memory entries;
// no beat is accepted during it. Reset is synchronous, active low.
`timescale 1ns / 1ps
`default_nettype none

module column_min_max_normalizer_unit #(
    parameter int MAX_COLUMNS = 1024,
    parameter int VALUE_BITS  = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cmmn_in_if.sink       i_in,
    cmmn_out_if.source    o_out
);
    localparam int DEPTH = (MAX_COLUMNS < cmmn_pkg::COLUMN_LIMIT) ?
                           MAX_COLUMNS : cmmn_pkg::COLUMN_LIMIT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SB    = cmmn_pkg::SCALED_BITS;
    localparam int QB    = cmmn_pkg::FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_NORM,
        S_CMP,
        S_DIV,
        S_DONE
    } t_state;

    t_state                       r_state;
    logic [AW-1:0]                r_col;
    logic signed [VALUE_BITS-1:0] r_val;
    logic                         r_in_range;
    logic [VALUE_BITS:0]          r_diff;
    logic [VALUE_BITS-1:0]        r_range;
    logic [SB-1:0]                r_res_scaled;
    logic                         r_res_pass;
    logic                         r_out_valid;
    logic [SB-1:0]                r_out_scaled;
    logic                         r_out_pass;

    logic                         w_accept;
    logic                         w_in_range;
    logic [AW-1:0]                w_addr;
    cmmn_pkg::t_stats_ctl         w_stats_ctl;
    cmmn_pkg::t_stats_sts         w_stats_sts;
    logic                         w_rd_seen;
    logic signed [VALUE_BITS-1:0] w_rd_min;
    logic signed [VALUE_BITS-1:0] w_rd_max;
    logic signed [VALUE_BITS-1:0] w_new_min;
    logic signed [VALUE_BITS-1:0] w_new_max;
    logic [VALUE_BITS:0]          w_diff;
    logic [VALUE_BITS:0]          w_span;
    logic                         w_diff_low;
    logic                         w_diff_high;
    cmmn_pkg::t_div_ctl           w_div_ctl;
    cmmn_pkg::t_div_sts           w_div_sts;
    logic [QB-1:0]                w_quot;
    logic [SB-1:0]                w_raw_scaled;

    // ---------------------------------------------------------------
    // Input handshake: one beat at a time, none during a clearing sweep
    // ---------------------------------------------------------------
    assign i_in.ready = (r_state == S_IDLE) && !w_stats_sts.busy;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_in_range = 32'(i_in.column) < 32'(MAX_COLUMNS);

    // Read is issued at accept; the scan write-back uses the latched column.
    assign w_addr = (r_state == S_IDLE) ? i_in.column[AW-1:0] : r_col;

    assign w_stats_ctl.rd_en = w_accept &&
        ((i_in.operation == cmmn_pkg::OP_SCAN && w_in_range) ||
         i_in.operation == cmmn_pkg::OP_NORMALIZE);
    assign w_stats_ctl.wr_en       = (r_state == S_SCAN);
    assign w_stats_ctl.clear_start = w_accept && i_in.operation == cmmn_pkg::OP_CLEAR;

    // first scan of a column seeds both bounds
    assign w_new_min = (!w_rd_seen || r_val < w_rd_min) ? r_val : w_rd_min;
    assign w_new_max = (!w_rd_seen || r_val > w_rd_max) ? r_val : w_rd_max;

    // differences carry one extra bit so signed operands never overflow
    assign w_diff = {r_val[VALUE_BITS-1], r_val} - {w_rd_min[VALUE_BITS-1], w_rd_min};
    assign w_span = {w_rd_max[VALUE_BITS-1], w_rd_max} - {w_rd_min[VALUE_BITS-1], w_rd_min};

    // clamp tests on registered diff: at or below min -> 0, at or above max -> 1.0
    assign w_diff_low  = r_diff[VALUE_BITS] || (r_diff == '0);
    assign w_diff_high = r_diff[VALUE_BITS-1:0] >= r_range;

    assign w_div_ctl.start = (r_state == S_CMP) && !w_diff_low && !w_diff_high;

    // raw pass-through value, sign-extended or truncated to the result width
    if (VALUE_BITS >= SB) begin : g_trunc
        assign w_raw_scaled = r_val[SB-1:0];
    end else begin : g_sext
        assign w_raw_scaled = {{(SB - VALUE_BITS){r_val[VALUE_BITS-1]}}, r_val};
    end

    cmmn_stats #(
        .DEPTH      (DEPTH),
        .AW         (AW),
        .VALUE_BITS (VALUE_BITS)
    ) u_stats (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_stats_ctl),
        .i_addr    (w_addr),
        .i_wr_min  (w_new_min),
        .i_wr_max  (w_new_max),
        .o_rd_seen (w_rd_seen),
        .o_rd_min  (w_rd_min),
        .o_rd_max  (w_rd_max),
        .o_sts     (w_stats_sts)
    );

    cmmn_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend (r_diff[VALUE_BITS-1:0]),
        .i_divisor  (r_range),
        .o_quotient (w_quot),
        .o_sts      (w_div_sts)
    );

    // ---------------------------------------------------------------
    // Sequencer and output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // S_DONE owns the output register in its own cycle
            if (r_out_valid && o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_col      <= i_in.column[AW-1:0];
                        r_val      <= i_in.value;
                        r_in_range <= w_in_range;
                        case (i_in.operation)
                            cmmn_pkg::OP_SCAN: begin
                                if (w_in_range) begin
                                    r_state <= S_SCAN;
                                end
                            end
                            cmmn_pkg::OP_NORMALIZE: begin
                                r_state <= S_NORM;
                            end
                            default: begin
                                // clear handled by the stats sweep; code three ignored
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_state <= S_IDLE;
                end
                S_NORM: begin
                    r_diff  <= w_diff;
                    r_range <= w_span[VALUE_BITS-1:0];
                    if (!r_in_range || !w_rd_seen || w_rd_min == w_rd_max) begin
                        r_res_scaled <= w_raw_scaled;
                        r_res_pass   <= 1'b1;
                        r_state      <= S_DONE;
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_res_pass <= 1'b0;
                    if (w_diff_low) begin
                        r_res_scaled <= '0;
                        r_state      <= S_DONE;
                    end else if (w_diff_high) begin
                        r_res_scaled <= cmmn_pkg::ONE_Q15;
                        r_state      <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_sts.done) begin
                        r_res_scaled <= {{(SB - QB){1'b0}}, w_quot};
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    // wait until the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_scaled <= r_res_scaled;
                        r_out_pass   <= r_res_pass;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.scaled         = r_out_scaled;
    assign o_out.passed_through = r_out_pass;

`ifndef ASSERT_OFF
    a_clear_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.operation == cmmn_pkg::OP_CLEAR) |=> w_stats_sts.busy)
        else $error("clear beat did not start the clearing sweep");

    a_scaled_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.passed_through) |->
        (!o_out.scaled[SB-1] && o_out.scaled[SB-2:0] <= cmmn_pkg::ONE_Q15[SB-2:0]))
        else $error("normalized result outside 0..1.0");

    a_no_accept_while_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.busy |-> !i_in.ready)
        else $error("input ready while divider is running");
`endif

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the column min-max normalizer: directed and random beats.
`timescale 1ns / 1ps

module tb;

    localparam int VAL_BITS      = 16;
    localparam int DRAIN_CYCLES  = 40;
    localparam int PHASE_BEATS   = 300;
    localparam logic [cmmn_pkg::OP_BITS-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [cmmn_pkg::SCALED_BITS-1:0] scaled;
        logic                                    passed_through;
    } t_scaled_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cmmn_in_if #(.VALUE_BITS(VAL_BITS)) in_ch ();
    cmmn_out_if                         out_ch ();

    column_min_max_normalizer_unit #(
        .MAX_COLUMNS (cmmn_pkg::COLUMN_LIMIT),
        .VALUE_BITS  (VAL_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // Shadow column statistics; the column field cannot exceed the table size.
    logic signed [VAL_BITS-1:0] col_lo   [cmmn_pkg::COLUMN_LIMIT];
    logic signed [VAL_BITS-1:0] col_hi   [cmmn_pkg::COLUMN_LIMIT];
    bit                         col_seen [cmmn_pkg::COLUMN_LIMIT];

    t_scaled_beat expected_q[$];
    int           errors;
    int           accepted_beats;
    int           src_idle_pct;
    int           sink_stall_pct;

    // Apply one accepted beat to the shadow state and queue its result, if any.
    task automatic fold_beat(input logic [cmmn_pkg::OP_BITS-1:0] op,
                             input logic [cmmn_pkg::COLUMN_BITS-1:0] col,
                             input logic signed [VAL_BITS-1:0] val);
        longint       span;
        longint       offset;
        longint       quo;
        t_scaled_beat beat;
        case (op)
            cmmn_pkg::OP_CLEAR: begin
                foreach (col_seen[i]) col_seen[i] = 1'b0;
            end
            cmmn_pkg::OP_SCAN: begin
                if (!col_seen[col]) begin
                    col_lo[col]   = val;
                    col_hi[col]   = val;
                    col_seen[col] = 1'b1;
                end else begin
                    if (val < col_lo[col]) col_lo[col] = val;
                    if (val > col_hi[col]) col_hi[col] = val;
                end
            end
            cmmn_pkg::OP_NORMALIZE: begin
                beat.passed_through = 1'b0;
                if (!col_seen[col] || col_lo[col] == col_hi[col]) begin
                    beat.scaled         = {val[VAL_BITS-1], val};
                    beat.passed_through = 1'b1;
                end else begin
                    span   = longint'(col_hi[col]) - longint'(col_lo[col]);
                    offset = longint'(val) - longint'(col_lo[col]);
                    if (offset <= 0) begin
                        quo = 0;
                    end else if (offset >= span) begin
                        quo = longint'(cmmn_pkg::ONE_Q15);
                    end else begin
                        quo = (offset * longint'(cmmn_pkg::ONE_Q15)) / span;
                        if (quo > longint'(cmmn_pkg::ONE_Q15)) begin
                            quo = longint'(cmmn_pkg::ONE_Q15);
                        end
                    end
                    beat.scaled = quo[cmmn_pkg::SCALED_BITS-1:0];
                end
                expected_q = {expected_q, beat};
            end
            default: ;
        endcase
    endtask

    // Drive one beat, with random sender gaps, and hold it until accepted.
    task automatic send_beat(input logic [cmmn_pkg::OP_BITS-1:0] op,
                             input logic [cmmn_pkg::COLUMN_BITS-1:0] col,
                             input logic signed [VAL_BITS-1:0] val);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.column    <= col;
        in_ch.value     <= val;
        do @(posedge i_clk); while (!in_ch.ready);
        fold_beat(op, col, val);
        if (op != OP_UNUSED) accepted_beats++;
    endtask

    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_q.size() != 0);
    endtask

    // Full-range value, or one near the pass center so ranges stay narrow.
    function automatic logic signed [VAL_BITS-1:0] pick_value(
        input logic signed [VAL_BITS-1:0] center);
        if ($urandom_range(3) == 0) return VAL_BITS'($urandom);
        return center + VAL_BITS'($urandom_range(64)) - VAL_BITS'(32);
    endfunction

    task automatic test_unscanned_columns();
        send_beat(cmmn_pkg::OP_NORMALIZE, 10'd0, -16'sd32768);
        send_beat(cmmn_pkg::OP_NORMALIZE, 10'd1023, 16'sd32767);
        send_beat(cmmn_pkg::OP_NORMALIZE, 10'd512, 16'sd0);
    endtask

    task automatic test_full_span();
        send_beat(cmmn_pkg::OP_SCAN, 10'd0, -16'sd32768);
        send_beat(cmmn_pkg::OP_SCAN, 10'd0, 16'sd32767);
        send_beat(cmmn_pkg::OP_NORMALIZE, 10'd0, -16'sd32768);
        send_beat(cmmn_pkg::OP_NORMALIZE, 10'd0, 16'sd32767);
        send_beat(cmmn_pkg::OP_NORMALIZE, 10'd0, 16'sd0);
        send_beat(cmmn_pkg::OP_NORMALIZE, 10'd0, -16'sd1);
    endtask

    task automatic test_clamp_and_flat();
        send_beat(cmmn_pkg::OP_SCAN, 10'd5, 16'sd10);
        send_beat(cmmn_pkg::OP_SCAN, 10'd5, 16'sd20);
        send_beat(cmmn_pkg::OP_SCAN, 10'd5, 16'sd15);
        send_beat(cmmn_pkg::OP_NORMALIZE, 10'd5, 16'sd5);     // below minimum
        send_beat(cmmn_pkg::OP_NORMALIZE, 10'd5, 16'sd25);    // above maximum
        send_beat(cmmn_pkg::OP_NORMALIZE, 10'd5, 16'sd15);
        send_beat(cmmn_pkg::OP_NORMALIZE, 10'd5, 16'sd20);
        send_beat(cmmn_pkg::OP_SCAN, 10'd1023, 16'sd100);
        send_beat(cmmn_pkg::OP_SCAN, 10'd1023, 16'sd100);
        send_beat(cmmn_pkg::OP_NORMALIZE, 10'd1023, 16'sd100); // zero range
        send_beat(cmmn_pkg::OP_NORMALIZE, 10'd1023, -16'sd7);
    endtask

    task automatic test_clear_and_ignored();
        send_beat(OP_UNUSED, 10'd5, 16'sd1);
        send_beat(cmmn_pkg::OP_CLEAR, 10'd0, 16'sd0);
        send_beat(cmmn_pkg::OP_NORMALIZE, 10'd5, 16'sd15);    // forgotten column
        send_beat(cmmn_pkg::OP_SCAN, 10'd5, 16'sd3);          // reseeds min and max
        send_beat(cmmn_pkg::OP_NORMALIZE, 10'd5, 16'sd3);
    endtask

    // Mostly scan-then-normalize passes over a few columns, plus stray beats.
    task automatic test_random_stream(input int beats);
        logic [cmmn_pkg::COLUMN_BITS-1:0] cols[6];
        logic signed [VAL_BITS-1:0]       center;
        int                               ncols;
        int                               stop_at;
        stop_at = accepted_beats + beats;
        while (accepted_beats < stop_at) begin
            if ($urandom_range(99) < 85) begin
                if ($urandom_range(99) < 15) begin
                    send_beat(cmmn_pkg::OP_CLEAR, cmmn_pkg::COLUMN_BITS'($urandom), 16'sd0);
                end
                ncols  = $urandom_range(1, 6);
                center = VAL_BITS'($urandom);
                for (int c = 0; c < ncols; c++) begin
                    cols[c] = cmmn_pkg::COLUMN_BITS'(
                        $urandom_range(cmmn_pkg::COLUMN_LIMIT - 1));
                end
                for (int c = 0; c < ncols; c++) begin
                    repeat ($urandom_range(1, 4)) begin
                        send_beat(cmmn_pkg::OP_SCAN, cols[c], pick_value(center));
                    end
                end
                repeat ($urandom_range(2, 10)) begin
                    send_beat(cmmn_pkg::OP_NORMALIZE, cols[$urandom_range(ncols - 1)],
                              pick_value(center));
                end
            end else begin
                send_beat(cmmn_pkg::OP_BITS'($urandom_range(3)),
                          cmmn_pkg::COLUMN_BITS'($urandom), VAL_BITS'($urandom));
            end
        end
    endtask

    // Result checker and receiver back-pressure.
    always @(posedge i_clk) begin : check_results
        t_scaled_beat want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result: scaled %0d passed_through %0b",
                       $signed(out_ch.scaled), out_ch.passed_through);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (out_ch.scaled !== want.scaled) begin
                    $error("scaled: expected %0d, got %0d",
                           $signed(want.scaled), $signed(out_ch.scaled));
                    errors++;
                end
                if (out_ch.passed_through !== want.passed_through) begin
                    $error("passed_through: expected %0b, got %0b",
                           want.passed_through, out_ch.passed_through);
                    errors++;
                end
            end
        end
        out_ch.ready <= i_rst_n && ($urandom_range(99) >= sink_stall_pct);
    end

    initial begin
        errors          = 0;
        accepted_beats  = 0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        foreach (col_seen[i]) col_seen[i] = 1'b0;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= cmmn_pkg::OP_SCAN;
        in_ch.column    <= '0;
        in_ch.value     <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_unscanned_columns();
        test_full_span();
        test_clamp_and_flat();
        test_clear_and_ignored();
        wait_for_results();

        test_random_stream(PHASE_BEATS);
        wait_for_results();
        src_idle_pct = 71;
        test_random_stream(PHASE_BEATS);
        wait_for_results();
        src_idle_pct   = 0;
        sink_stall_pct = 71;
        test_random_stream(PHASE_BEATS);
        wait_for_results();
        src_idle_pct   = 38;
        sink_stall_pct = 38;
        test_random_stream(PHASE_BEATS);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("tb: FAIL");
        $finish;
    end
endmodule
